// ===== hdl/tcs_pkg.sv =====
`default_nettype none
package tcs_pkg;
	localparam int NODE_COUNT    = 64;
	localparam int NODE_W        = 6;
	localparam int FRACTION_BITS = 16;
	localparam int THR_W         = FRACTION_BITS + 1;
	localparam int CNT_W         = 7;
	localparam int KIND_W        = 3;

	localparam logic [THR_W-1:0] THR_RESET = THR_W'(1) << (FRACTION_BITS - 1);

	typedef enum logic [KIND_W-1:0] {
		K_ADD_EDGE  = 3'd0,
		K_SET_THR   = 3'd1,
		K_CLEAR     = 3'd2,
		K_SEED_PROP = 3'd3,
		K_MARK      = 3'd4,
		K_PROP_ALL  = 3'd5
	} kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_MIRROR,
		ST_LOAD_ALL,
		ST_POP,
		ST_POP_WAIT,
		ST_SCAN,
		ST_COL_RD,
		ST_COL_ACC,
		ST_MUL,
		ST_CMP,
		ST_CLR_THR,
		ST_CLR_ROW,
		ST_DONE
	} state_t;
endpackage
`default_nettype wire

// ===== hdl/tcs_if.sv =====
`default_nettype none
interface tcs_in_if;
	logic                          valid;
	logic                          ready;
	logic [tcs_pkg::KIND_W-1:0]    kind;
	logic [tcs_pkg::NODE_W-1:0]    node_a;
	logic [tcs_pkg::NODE_W-1:0]    node_b;
	logic [tcs_pkg::THR_W-1:0]     threshold_value;
	modport source (output valid, kind, node_a, node_b, threshold_value, input ready);
	modport sink   (input valid, kind, node_a, node_b, threshold_value, output ready);
endinterface

interface tcs_out_if;
	logic                       valid;
	logic                       ready;
	logic [tcs_pkg::CNT_W-1:0]  spread_count;
	modport source (output valid, spread_count, input ready);
	modport sink   (input valid, spread_count, output ready);
endinterface

interface tcs_cfg_if;
	logic valid;
	logic ready;
	logic undirected;
	modport source (output valid, undirected, input ready);
	modport sink   (input valid, undirected, output ready);
endinterface
`default_nettype wire

// ===== hdl/threshold_cascade_spread_core.sv =====
// Linear threshold influence cascade over a 64-node graph.
// Channels: in (kind, node_a, node_b, threshold_value), out (spread_count),
// cfg (undirected bit). Each is valid/ready; a transaction happens when both
// are high at a rising clk edge. Every input transaction yields exactly one
// output transaction carrying the active node count after the item.
// One item at a time: in.ready is high only while the sequencer is idle and
// no result is waiting in the output register.
// Threshold, mark and clear items pass through ST_DECODE and ST_DONE before
// out.valid rises; a directed edge adds ST_CLR_ROW and a mirrored edge also
// ST_MIRROR. Propagate-all first loads the queue. Propagation pops each queued
// node and scans its 64 neighbours; every candidate neighbour costs a column
// count over 64 rows through the single edge-matrix read port plus a multiply
// and a compare. After arst_n is released the block sweeps the edge matrix and
// threshold memory to their reset values before in.ready rises; cfg writes
// are taken at any time. A stalled receiver holds the result in the output
// register and the block waits.
`default_nettype none
module threshold_cascade_spread_core (
	input  wire         clk,
	input  wire         arst_n,
	tcs_in_if.sink      in,
	tcs_out_if.source   out,
	tcs_cfg_if.sink     cfg
);
	import tcs_pkg::*;

	state_t state_q, state_d;

	logic undirected_q;
	logic [NODE_COUNT-1:0] active_q, queued_q;
	logic [CNT_W-1:0] total_q;
	logic [NODE_W:0] head_q, tail_q;
	logic [NODE_W:0] cnt_q;        // sweep / scan / row counter
	logic [NODE_W-1:0] cand_q;
	logic [CNT_W-1:0] inc_q, act_q;
	logic [KIND_W-1:0] kind_q;
	logic [NODE_W-1:0] a_q, b_q;
	logic [THR_W-1:0] thr_in_q;
	logic [NODE_COUNT-1:0] row_q;
	logic [THR_W+CNT_W-1:0] prod_q;
	logic out_valid_q;
	logic [CNT_W-1:0] out_cnt_q;
	logic row_load_q;
	logic [NODE_COUNT-1:0] row_w;

	// memories
	logic [NODE_COUNT-1:0] edge_mem [NODE_COUNT];
	logic [THR_W-1:0] thr_mem [NODE_COUNT];
	logic [NODE_W-1:0] pq_mem [NODE_COUNT];
	logic [NODE_COUNT-1:0] erd_q;
	logic [THR_W-1:0] trd_q;
	logic [NODE_W-1:0] qrd_q;

	logic e_we; logic [NODE_W-1:0] e_wa, e_ra; logic [NODE_COUNT-1:0] e_wd;
	logic t_we; logic [NODE_W-1:0] t_wa, t_ra; logic [THR_W-1:0] t_wd;

	always_ff @(posedge clk) begin
		if (e_we) edge_mem[e_wa] <= e_wd;
		erd_q <= edge_mem[e_ra];
		if (t_we) thr_mem[t_wa] <= t_wd;
		trd_q <= thr_mem[t_ra];
		qrd_q <= pq_mem[head_q[NODE_W-1:0]];
	end

	// enqueue request from the sequencer
	logic enq; logic [NODE_W-1:0] enq_n;
	logic can_enq;
	assign can_enq = enq && !queued_q[enq_n] && !tail_q[NODE_W];
	always_ff @(posedge clk) begin
		if (can_enq) pq_mem[tail_q[NODE_W-1:0]] <= enq_n;
	end

	assign cfg.ready = 1'b1;
	assign in.ready  = (state_q == ST_IDLE) && !out_valid_q;
	assign out.valid = out_valid_q;
	assign out.spread_count = out_cnt_q;

	logic [NODE_W-1:0] cnt_lo;
	assign cnt_lo = cnt_q[NODE_W-1:0];

	// row of the popped node: straight from the read port on the first scan cycle
	assign row_w = row_load_q ? erd_q : row_q;

	// next state and memory controls
	always_comb begin
		state_d = state_q;
		e_we = 1'b0; e_wa = a_q; e_wd = erd_q; e_ra = a_q;
		t_we = 1'b0; t_wa = cnt_lo; t_wd = THR_RESET; t_ra = cand_q;
		enq = 1'b0; enq_n = cnt_lo;
		unique case (state_q)
			ST_CLR_THR: begin
				t_we = 1'b1; e_we = 1'b1; e_wa = cnt_lo; e_wd = '0;
				if (cnt_q == (NODE_W+1)'(NODE_COUNT - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: if (in.valid && in.ready) state_d = ST_DECODE;
			ST_DECODE: begin
				e_ra = a_q;
				unique case (kind_q)
					K_ADD_EDGE:  state_d = ST_CLR_ROW;
					K_SET_THR: begin
						t_we = 1'b1; t_wa = a_q; t_wd = thr_in_q; state_d = ST_DONE;
					end
					K_SEED_PROP: begin
						enq = 1'b1; enq_n = a_q; state_d = ST_POP;
					end
					K_PROP_ALL:  state_d = ST_LOAD_ALL;
					default:     state_d = ST_DONE;
				endcase
			end
			ST_CLR_ROW: begin
				// read-modify-write of row a
				e_we = 1'b1; e_wa = a_q; e_wd = erd_q | (NODE_COUNT'(1) << b_q);
				e_ra = b_q;
				state_d = undirected_q ? ST_MIRROR : ST_DONE;
			end
			ST_MIRROR: begin
				e_we = 1'b1; e_wa = b_q;
				e_wd = erd_q | (NODE_COUNT'(1) << a_q);
				if (a_q == b_q) e_wd = erd_q | (NODE_COUNT'(1) << a_q)
					| (NODE_COUNT'(1) << b_q);
				state_d = ST_DONE;
			end
			ST_LOAD_ALL: begin
				enq = active_q[cnt_lo]; enq_n = cnt_lo;
				if (cnt_q == (NODE_W+1)'(NODE_COUNT - 1)) state_d = ST_POP;
			end
			ST_POP: state_d = (head_q < tail_q) ? ST_POP_WAIT : ST_DONE;
			ST_POP_WAIT: begin
				e_ra = qrd_q; state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (cnt_q[NODE_W]) state_d = ST_POP;
				else if (row_w[cnt_lo] && !active_q[cnt_lo]) begin
					e_ra = '0; state_d = ST_COL_RD;
				end
			end
			ST_COL_RD: begin
				e_ra = cnt_lo; state_d = ST_COL_ACC;
			end
			ST_COL_ACC: begin
				e_ra = cnt_lo;
				if (cnt_q == (NODE_W+1)'(NODE_COUNT - 1)) state_d = ST_MUL;
				else state_d = ST_COL_RD;
			end
			ST_MUL: state_d = ST_CMP;
			ST_CMP: begin
				if ((FRACTION_BITS+CNT_W+1)'(act_q) << FRACTION_BITS >=
					(FRACTION_BITS+CNT_W+1)'(prod_q)) begin
					enq = 1'b1; enq_n = cand_q;
				end
				state_d = ST_SCAN;
			end
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	logic pass;
	assign pass = ((FRACTION_BITS+CNT_W+1)'(act_q) << FRACTION_BITS) >=
		(FRACTION_BITS+CNT_W+1)'(prod_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR_THR;
			undirected_q <= 1'b1;
			active_q <= '0; queued_q <= '0; total_q <= '0;
			head_q <= '0; tail_q <= '0; cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg.valid) undirected_q <= cfg.undirected;
			if (out_valid_q && out.ready) out_valid_q <= 1'b0;
			if (can_enq) begin
				queued_q[enq_n] <= 1'b1;
				tail_q <= tail_q + 1'b1;
			end
			unique case (state_q)
				ST_CLR_THR: cnt_q <= cnt_q + 1'b1;
				ST_IDLE: begin
					head_q <= '0; tail_q <= '0; queued_q <= '0; cnt_q <= '0;
				end
				ST_DECODE: begin
					cnt_q <= '0;
					if (kind_q == K_CLEAR) begin
						active_q <= '0; total_q <= '0;
					end
					if ((kind_q == K_MARK || kind_q == K_SEED_PROP) && !active_q[a_q]) begin
						active_q[a_q] <= 1'b1; total_q <= total_q + 1'b1;
					end
				end
				ST_LOAD_ALL: cnt_q <= cnt_q + 1'b1;
				ST_POP: if (head_q < tail_q) head_q <= head_q + 1'b1;
				ST_POP_WAIT: cnt_q <= '0;
				ST_SCAN: begin
					if (!cnt_q[NODE_W] && row_w[cnt_lo] && !active_q[cnt_lo]) begin
						cand_q <= cnt_lo;
						inc_q <= '0; act_q <= '0;
						cnt_q <= '0;
					end else if (!cnt_q[NODE_W]) cnt_q <= cnt_q + 1'b1;
				end
				ST_COL_ACC: begin
					if (erd_q[cand_q]) begin
						inc_q <= inc_q + 1'b1;
						act_q <= act_q + CNT_W'(active_q[cnt_lo]);
					end
					cnt_q <= cnt_q + 1'b1;
				end
				ST_CMP: begin
					if (pass) begin
						active_q[cand_q] <= 1'b1; total_q <= total_q + 1'b1;
					end
					cnt_q <= {1'b0, cand_q} + 1'b1;
				end
				ST_DONE: begin
					out_valid_q <= 1'b1; out_cnt_q <= total_q;
				end
				default: ;
			endcase
		end
	end

	// payload and datapath registers
	always_ff @(posedge clk) begin
		if (in.valid && in.ready) begin
			kind_q <= in.kind; a_q <= in.node_a; b_q <= in.node_b;
			thr_in_q <= in.threshold_value;
		end
		if (state_q == ST_MUL) prod_q <= (THR_W+CNT_W)'(trd_q) * (THR_W+CNT_W)'(inc_q);
	end

	// row of the popped node arrives in the cycle after ST_POP_WAIT
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) row_load_q <= 1'b0;
		else row_load_q <= (state_q == ST_POP_WAIT);
	end
	always_ff @(posedge clk) begin
		if (row_load_q) row_q <= erd_q;
	end
endmodule
`default_nettype wire

// ===== hdl/tcs_checker.sv =====
`default_nettype none
module tcs_checker (
	input wire clk,
	input wire arst_n,
	input wire in_valid,
	input wire in_ready,
	input wire out_valid,
	input wire out_ready,
	input wire [6:0] spread_count
);
	// a result never exceeds the node count
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> spread_count <= 7'd64) else $error("count out of range");
	// no new transaction while a result waits
	a_block: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("ready with pending result");
	// result held while stalled
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(spread_count))
		else $error("result dropped");
	// an accepted item is not immediately answered
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !out_valid) else $error("result too early");
endmodule

bind threshold_cascade_spread_core tcs_checker u_tcs_checker (
	.clk(clk), .arst_n(arst_n),
	.in_valid(in.valid), .in_ready(in.ready),
	.out_valid(out.valid), .out_ready(out.ready),
	.spread_count(out.spread_count)
);
`default_nettype wire
